// ----- src/bitmap_run_suballocator_top_assert.svh -----
// Assertion macros for the bitmap run suballocator.
// Depends on nothing; included by the files that assert.
`ifndef BITMAP_RUN_SUBALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_RUN_SUBALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that a condition implies another in the same cycle.
`define BRS_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed: implication");
// Check that a condition implies another in the next cycle.
`define BRS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed: next-cycle implication");
`else
`define BRS_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define BRS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// ----- src/bmrs_pkg.sv -----
// Shared types and constants for the bitmap run suballocator.
// Depends on nothing.
package bmrs_pkg;

	// Field widths of the request and result words
	localparam int RUN_LEN_W = 6;
	localparam int MASK_W    = 32;
	localparam int POS_W     = 5;
	localparam int LONG_W    = 6;

	// Request command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_NOROOM = 2'd1,
		ST_BAD    = 2'd2
	} status_t;

endpackage

// ----- src/bitmap_run_suballocator_top.sv -----
// First-fit contiguous run allocator over a free bitmap of SUB_BLOCKS sub-blocks.
// Depends on bmrs_pkg and bitmap_run_suballocator_top_assert.svh.

// Usage: the block takes one request word per cycle and returns one result word
// per request, in order. The result word is held in the stage 3 register until it
// is taken, which happens when the output is not stalled; only a stalled output
// holds the input off. A request is registered, then the run search, grant and
// map update are done combinationally against the free map register,
// so the next request always sees the map left by the one before it. The longest free
// run and the full and empty flags are worked out from a copy of the new map in
// the following stage. All sub-blocks are free after reset; a bad allocate
// (zero or oversized run) or a free that names an already free sub-block is
// flagged with the bad-request status and leaves the map unchanged.
`include "bitmap_run_suballocator_top_assert.svh"

module bitmap_run_suballocator_top #(
	parameter int SUB_BLOCKS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [bmrs_pkg::RUN_LEN_W-1:0]     run_length,
	input  logic [bmrs_pkg::MASK_W-1:0]        release_mask,
	output logic                               out_valid,
	input  logic                               out_stall,
	output bmrs_pkg::status_t                  status,
	output logic [bmrs_pkg::POS_W-1:0]         start_pos,
	output logic [bmrs_pkg::MASK_W-1:0]        run_mask,
	output logic [bmrs_pkg::LONG_W-1:0]        longest_free,
	output logic                               is_full,
	output logic                               is_empty
);
	import bmrs_pkg::*;

	localparam int W    = SUB_BLOCKS;
	localparam int LW   = $clog2(SUB_BLOCKS + 1);
	localparam int NLVL = LW;
	localparam int PW   = $clog2(SUB_BLOCKS);

	// Build maps of positions that start a free run of 1, 2, 4, ... sub-blocks
	function automatic void run_levels(input logic [W-1:0] m,
			output logic [W-1:0] lvl [NLVL]);
		lvl[0] = m;
		for (int j = 1; j < NLVL; j++) begin
			lvl[j] = lvl[j-1] & (lvl[j-1] >> (1 << (j - 1)));
		end
	endfunction

	// Positions that start a free run of at least n sub-blocks
	function automatic logic [W-1:0] run_starts(input logic [W-1:0] m,
			input logic [LW-1:0] n);
		logic [W-1:0]  lvl [NLVL];
		logic [W-1:0]  acc;
		logic [LW-1:0] off;
		run_levels(m, lvl);
		acc = '1;
		off = '0;
		for (int j = 0; j < NLVL; j++) begin
			if (n[j]) begin
				acc = acc & (lvl[j] >> off);
				off = off + LW'(1 << j);
			end
		end
		return acc;
	endfunction

	// Length of the longest free run, found one binary digit at a time
	function automatic logic [LW-1:0] longest_run(input logic [W-1:0] m);
		logic [W-1:0]  lvl [NLVL];
		logic [W-1:0]  acc;
		logic [W-1:0]  cand;
		logic [LW-1:0] len;
		run_levels(m, lvl);
		acc = '1;
		len = '0;
		for (int j = NLVL - 1; j >= 0; j--) begin
			cand = acc & (lvl[j] >> len);
			if (|cand) begin
				acc = cand;
				len = len + LW'(1 << j);
			end
		end
		return len;
	endfunction

	// Stage 1: registered request
	logic                 s1_valid;
	logic                 cmd_s1;
	logic [RUN_LEN_W-1:0] run_length_s1;
	logic [MASK_W-1:0]    release_mask_s1;

	// Stage 2: decision and new map copy
	logic                 s2_valid;
	status_t              status_s2;
	logic [PW-1:0]        pos_s2;
	logic [W-1:0]         grant_s2;
	logic [W-1:0]         map_s2;

	// Stage 3: result word
	logic                 s3_valid;
	status_t              status_s3;
	logic [POS_W-1:0]     start_pos_s3;
	logic [MASK_W-1:0]    run_mask_s3;
	logic [LONG_W-1:0]    longest_s3;
	logic                 full_s3;
	logic                 empty_s3;
	logic                 fail_s3;

	logic [W-1:0]         free_map_q;

	logic                 adv_s1;
	logic                 adv_s2;

	// Decision logic signals
	logic                 len_bad;
	logic [LW-1:0]        len_w;
	logic [W-1:0]         starts;
	logic [PW-1:0]        pos_c;
	logic [W:0]           one_hot;
	logic [W-1:0]         len_mask;
	logic [W-1:0]         grant_c;
	logic [W-1:0]         rel_c;
	logic [W-1:0]         map_c;
	status_t              status_c;
	logic [LW-1:0]        longest_c;

	// Handshake: advance a stage when the next one is empty or moving
	assign adv_s2   = s2_valid && (!s3_valid || !out_stall);
	assign adv_s1   = s1_valid && (!s2_valid || adv_s2);
	assign in_stall = s1_valid && !adv_s1;

	// Capture the request word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1          <= cmd;
			run_length_s1   <= run_length;
			release_mask_s1 <= release_mask;
		end
	end

	// Search for the lowest fitting run and form the grant
	always_comb begin
		len_bad  = (run_length_s1 == '0) || (int'(run_length_s1) > SUB_BLOCKS);
		len_w    = LW'(run_length_s1);
		starts   = run_starts(free_map_q, len_w);
		pos_c    = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (starts[i]) begin
				pos_c = PW'(i);
			end
		end
		one_hot  = (W + 1)'(1) << len_w;
		len_mask = W'(one_hot - (W + 1)'(1));
		rel_c    = W'(release_mask_s1);
	end

	// Pick status and new map
	always_comb begin
		status_c = ST_DONE;
		grant_c  = '0;
		map_c    = free_map_q;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (len_bad) begin
					status_c = ST_BAD;
				end else if (starts == '0) begin
					status_c = ST_NOROOM;
				end else begin
					grant_c = len_mask << pos_c;
					map_c   = free_map_q & ~grant_c;
				end
			end
			CMD_FREE: begin
				if ((free_map_q & rel_c) != '0) begin
					status_c = ST_BAD;
				end else begin
					map_c = free_map_q | rel_c;
				end
			end
			default: begin
				status_c = ST_BAD;
			end
		endcase
	end

	// Update the free map as the request leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map_q <= '1;
			s2_valid   <= 1'b0;
		end else begin
			if (adv_s1) begin
				free_map_q <= map_c;
			end
			if (!s2_valid || adv_s2) begin
				s2_valid <= adv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= status_c;
			pos_s2    <= (status_c == ST_DONE && cmd_s1 == CMD_ALLOC) ? pos_c : '0;
			grant_s2  <= grant_c;
			map_s2    <= map_c;
		end
	end

	// Summarize the new map
	assign longest_c = longest_run(map_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else if (!s3_valid || !out_stall) begin
			s3_valid <= adv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			status_s3    <= status_s2;
			start_pos_s3 <= POS_W'(pos_s2);
			run_mask_s3  <= MASK_W'(grant_s2);
			longest_s3   <= LONG_W'(longest_c);
			full_s3      <= (map_s2 == '0);
			empty_s3     <= (map_s2 == '1);
		end
	end

	// Drive the result word
	assign out_valid    = s3_valid;
	assign status       = status_s3;
	assign start_pos    = start_pos_s3;
	assign run_mask     = run_mask_s3;
	assign longest_free = longest_s3;
	assign is_full      = full_s3;
	assign is_empty     = empty_s3;

	assign fail_s3 = s3_valid && (status_s3 != ST_DONE);

	// A grant only takes sub-blocks that were free
	`BRS_ASSERT_IMPLIES(a_grant_free, clk, arst_n, adv_s1, (grant_c & ~free_map_q) == '0)
	// A failed request carries no grant
	`BRS_ASSERT_IMPLIES(a_fail_no_grant, clk, arst_n, fail_s3, !(|run_mask_s3) && !(|start_pos_s3))
	// Full and empty never both hold
	`BRS_ASSERT_IMPLIES(a_full_empty, clk, arst_n, s3_valid, !(full_s3 && empty_s3))
	// The map stays put unless a request leaves stage 1
	`BRS_ASSERT_NEXT(a_map_hold, clk, arst_n, !adv_s1, $stable(free_map_q))

endmodule
